// ===== rtl/core/ppmfd_pkg.sv =====
package ppmfd_pkg;

    // default channel buffer depth
    localparam int MAX_CHANNELS_DEF = 16;

    // fewest buffered channels that make a frame
    localparam int MIN_FRAME_CHANNELS = 2;

    // field widths
    localparam int TIME_W  = 32;
    localparam int VALUE_W = 16;
    localparam int NUM_W   = 4;
    localparam int COUNT_W = 5;
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 32;

    // configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_ADDR_W-1:0] REG_SYNC_MIN  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_SYNC_MAX  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_CHAN_MIN  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_CHAN_MAX  = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_CLAMP_MIN = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_CLAMP_MAX = 3'd5;

    localparam logic [CFG_DATA_W-1:0] SYNC_MIN_RST  = 16'd3000;
    localparam logic [CFG_DATA_W-1:0] SYNC_MAX_RST  = 16'd20000;
    localparam logic [CFG_DATA_W-1:0] CHAN_MIN_RST  = 16'd800;
    localparam logic [CFG_DATA_W-1:0] CHAN_MAX_RST  = 16'd2200;
    localparam logic [CFG_DATA_W-1:0] CLAMP_MIN_RST = 16'd1000;
    localparam logic [CFG_DATA_W-1:0] CLAMP_MAX_RST = 16'd2000;

    // commands from the controller to the datapath
    typedef struct packed {
        logic capture;     // take the timestamp, form the interval
        logic set_sync;    // sync gap seen: clear the slot count, set sync
        logic clr_sync;    // lose sync, clear the slot count
        logic store;       // buffer the clamped interval
        logic emit_start;  // latch the frame length, rewind the read index
        logic rd;          // read the store at the read index
        logic ld;          // load the output register from the read data
    } cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic is_sync;     // interval inside the sync window
        logic is_over;     // interval above the sync window
        logic is_chan;     // interval inside the channel window
        logic in_sync;
        logic slot_ge_min; // enough channels buffered for a frame
        logic slot_full;   // buffer holds every channel it can
        logic out_free;    // output register free or being taken
        logic emit_last;   // read index is on the final channel
    } status_t;

endpackage

// ===== rtl/core/ppmfd_ram.sv =====
module ppmfd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/ppmfd_ctrl.sv =====
module ppmfd_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  ppmfd_pkg::status_t status,
    output ppmfd_pkg::cmd_t    cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_CLASS = 2'd1;
    localparam logic [1:0] ST_RD    = 2'd2;
    localparam logic [1:0] ST_LD    = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_CLASS;
                end
            end
            ST_CLASS: begin
                state_next = ST_IDLE;
                if (status.is_sync) begin
                    cmd.set_sync = 1'b1;
                    if (status.in_sync && status.slot_ge_min) begin
                        cmd.emit_start = 1'b1;
                        state_next     = ST_RD;
                    end
                end else if (status.is_over) begin
                    cmd.clr_sync = 1'b1;
                end else if (status.in_sync && status.is_chan) begin
                    cmd.store = !status.slot_full;
                end else begin
                    cmd.clr_sync = 1'b1;
                end
            end
            ST_RD: begin
                if (status.out_free) begin
                    cmd.rd     = 1'b1;
                    state_next = ST_LD;
                end
            end
            ST_LD: begin
                cmd.ld     = 1'b1;
                state_next = status.emit_last ? ST_IDLE : ST_RD;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/core/ppmfd_dp.sv =====
module ppmfd_dp #(
    parameter int MAX_CHANNELS = ppmfd_pkg::MAX_CHANNELS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic [ppmfd_pkg::S_TDATA_W-1:0]  s_tdata,
    output logic [ppmfd_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic                             m_tlast,
    input  logic                             cfg_wr_en,
    input  logic [ppmfd_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [ppmfd_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    input  ppmfd_pkg::cmd_t                  cmd,
    output ppmfd_pkg::status_t               status
);

    localparam int SLOT_W = $clog2(MAX_CHANNELS + 1);
    localparam int IDX_W  = $clog2(MAX_CHANNELS);
    localparam int PAD_W  = ppmfd_pkg::M_TDATA_W - ppmfd_pkg::NUM_W
                          - ppmfd_pkg::VALUE_W - ppmfd_pkg::COUNT_W;

    // configuration registers
    logic [ppmfd_pkg::CFG_DATA_W-1:0] sync_min_reg, sync_max_reg;
    logic [ppmfd_pkg::CFG_DATA_W-1:0] chan_min_reg, chan_max_reg;
    logic [ppmfd_pkg::CFG_DATA_W-1:0] clamp_min_reg, clamp_max_reg;

    // decoder state
    logic [ppmfd_pkg::TIME_W-1:0] prev_reg;
    logic [ppmfd_pkg::TIME_W-1:0] interval_reg;
    logic                         in_sync_reg;
    logic [SLOT_W-1:0]            slot_reg;
    logic [SLOT_W-1:0]            emit_n_reg;
    logic [IDX_W-1:0]             rd_idx_reg;

    // output register
    logic                            m_valid_reg;
    logic [ppmfd_pkg::NUM_W-1:0]     out_num_reg;
    logic [ppmfd_pkg::VALUE_W-1:0]   out_value_reg;
    logic [ppmfd_pkg::COUNT_W-1:0]   out_count_reg;
    logic                            out_last_reg;

    logic [ppmfd_pkg::VALUE_W-1:0] clamp_lo;
    logic [ppmfd_pkg::VALUE_W-1:0] clamped;
    logic [ppmfd_pkg::VALUE_W-1:0] rd_data;
    logic                          emit_last;

    // configuration writes, unknown indexes ignored
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sync_min_reg  <= ppmfd_pkg::SYNC_MIN_RST;
            sync_max_reg  <= ppmfd_pkg::SYNC_MAX_RST;
            chan_min_reg  <= ppmfd_pkg::CHAN_MIN_RST;
            chan_max_reg  <= ppmfd_pkg::CHAN_MAX_RST;
            clamp_min_reg <= ppmfd_pkg::CLAMP_MIN_RST;
            clamp_max_reg <= ppmfd_pkg::CLAMP_MAX_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                ppmfd_pkg::REG_SYNC_MIN:  sync_min_reg  <= cfg_wr_data;
                ppmfd_pkg::REG_SYNC_MAX:  sync_max_reg  <= cfg_wr_data;
                ppmfd_pkg::REG_CHAN_MIN:  chan_min_reg  <= cfg_wr_data;
                ppmfd_pkg::REG_CHAN_MAX:  chan_max_reg  <= cfg_wr_data;
                ppmfd_pkg::REG_CLAMP_MIN: clamp_min_reg <= cfg_wr_data;
                ppmfd_pkg::REG_CLAMP_MAX: clamp_max_reg <= cfg_wr_data;
                default: begin
                end
            endcase
        end
    end

    // interval with 32-bit wrap
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            interval_reg <= s_tdata - prev_reg;
        end
    end

    // timestamp, sync flag and slot count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg    <= '0;
            in_sync_reg <= 1'b0;
            slot_reg    <= '0;
        end else begin
            if (cmd.capture) begin
                prev_reg <= s_tdata;
            end
            if (cmd.set_sync) begin
                in_sync_reg <= 1'b1;
                slot_reg    <= '0;
            end else if (cmd.clr_sync) begin
                in_sync_reg <= 1'b0;
                slot_reg    <= '0;
            end else if (cmd.store) begin
                slot_reg <= slot_reg + SLOT_W'(1);
            end
        end
    end

    // window tests on the interval
    assign status.is_sync = (interval_reg >= ppmfd_pkg::TIME_W'(sync_min_reg))
                         && (interval_reg <= ppmfd_pkg::TIME_W'(sync_max_reg));
    assign status.is_over = interval_reg > ppmfd_pkg::TIME_W'(sync_max_reg);
    assign status.is_chan = (interval_reg >= ppmfd_pkg::TIME_W'(chan_min_reg))
                         && (interval_reg <= ppmfd_pkg::TIME_W'(chan_max_reg));
    assign status.in_sync     = in_sync_reg;
    assign status.slot_ge_min = slot_reg >= SLOT_W'(ppmfd_pkg::MIN_FRAME_CHANNELS);
    assign status.slot_full   = slot_reg == SLOT_W'(MAX_CHANNELS);
    assign status.out_free    = !m_valid_reg || m_tready;
    assign status.emit_last   = emit_last;

    // lower clamp first, then upper
    assign clamp_lo = (interval_reg[ppmfd_pkg::VALUE_W-1:0] < clamp_min_reg)
                    ? clamp_min_reg : interval_reg[ppmfd_pkg::VALUE_W-1:0];
    assign clamped  = (clamp_lo > clamp_max_reg) ? clamp_max_reg : clamp_lo;

    // channel buffer
    ppmfd_ram #(
        .WIDTH (ppmfd_pkg::VALUE_W),
        .DEPTH (MAX_CHANNELS)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (cmd.store),
        .wr_addr (slot_reg[IDX_W-1:0]),
        .wr_data (clamped),
        .rd_en   (cmd.rd),
        .rd_addr (rd_idx_reg),
        .rd_data (rd_data)
    );

    // frame read-out position
    assign emit_last = SLOT_W'(rd_idx_reg) == (emit_n_reg - SLOT_W'(1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            emit_n_reg <= '0;
            rd_idx_reg <= '0;
        end else if (cmd.emit_start) begin
            emit_n_reg <= slot_reg;
            rd_idx_reg <= '0;
        end else if (cmd.ld) begin
            rd_idx_reg <= rd_idx_reg + IDX_W'(1);
        end
    end

    // output register, loaded only when empty
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.ld) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.ld) begin
            out_num_reg   <= ppmfd_pkg::NUM_W'(rd_idx_reg);
            out_value_reg <= rd_data;
            out_count_reg <= ppmfd_pkg::COUNT_W'(emit_n_reg);
            out_last_reg  <= emit_last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, out_count_reg, out_value_reg, out_num_reg};

endmodule

// ===== rtl/core/ppm_frame_decoder_core.sv =====
// ppm frame decoder
//
// s_ channel: one item per active edge, s_tdata carries the 32-bit
// microsecond timestamp. the block forms the interval to the previous edge
// and classifies it as sync gap, channel pulse or fault.
// m_ channel: when a sync gap closes a frame of two or more buffered
// channels, one item per channel is sent, first channel first, with
// m_tlast high on the final one.
// cfg port: plain write of the six window and clamp registers by index;
// write only while the block is idle.
// sequencing: an item that gives no result is accepted, then classified.
// a frame of n channels is read out in full before the next item is
// accepted: each result needs the registered read of the channel buffer
// and then a load of the output register. the first result follows the
// classify, read and load steps after the closing item is accepted.
// a stalled receiver holds the read-out loop; the final result can wait in
// the output register while the next item is accepted.
// reset: windows and clamps return to their defaults, sync is lost and the
// buffer count is cleared; the buffer contents are not cleared.
module ppm_frame_decoder_core #(
    parameter int MAX_CHANNELS = ppmfd_pkg::MAX_CHANNELS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // fields from bit 0: edge_time_us[31:0]
    input  logic [ppmfd_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // fields from bit 0: chan_number[3:0], chan_value_us[19:4],
    // frame_channels[24:20], zero pad[31:25]
    output logic [ppmfd_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic                             m_tlast,
    input  logic                             cfg_wr_en,
    input  logic [ppmfd_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [ppmfd_pkg::CFG_DATA_W-1:0] cfg_wr_data
);

    ppmfd_pkg::cmd_t    cmd;
    ppmfd_pkg::status_t status;

    // sequencer
    ppmfd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // interval, windows, buffer and output register
    ppmfd_dp #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tdata     (s_tdata),
        .m_tdata     (m_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tlast     (m_tlast),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .status      (status)
    );

`ifndef SYNTHESIS
    // a result is never loaded over one still waiting
    a_ld_into_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.ld |-> !m_tvalid)
        else $error("output register overwritten");

    // an accepted item is classified before the next is taken
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted during classification");

    // every buffer read is followed by a load of its data
    a_rd_then_ld: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.rd |=> cmd.ld)
        else $error("buffer read data not loaded");
`endif

endmodule

// ===== test/testbench.sv =====
// one channel of a committed frame, as it leaves the block
typedef struct packed {
    logic [3:0]  chan_number;
    logic [15:0] chan_value_us;
    logic [4:0]  frame_channels;
    logic        frame_last;
} chan_result_t;

// mirrors the decoder: windows, sync flag, channel buffer, frames still owed
class ppm_frame_scoreboard;
    logic [15:0]  cfg_reg [6];
    logic [31:0]  last_edge;
    bit           synced;
    int unsigned  slots;
    logic [15:0]  chan_store [ppmfd_pkg::MAX_CHANNELS_DEF];
    chan_result_t frame_queue [$];
    int unsigned  errors;

    function new();
        errors = 0;
        reset_state();
    endfunction

    function void reset_state();
        cfg_reg[ppmfd_pkg::REG_SYNC_MIN]  = ppmfd_pkg::SYNC_MIN_RST;
        cfg_reg[ppmfd_pkg::REG_SYNC_MAX]  = ppmfd_pkg::SYNC_MAX_RST;
        cfg_reg[ppmfd_pkg::REG_CHAN_MIN]  = ppmfd_pkg::CHAN_MIN_RST;
        cfg_reg[ppmfd_pkg::REG_CHAN_MAX]  = ppmfd_pkg::CHAN_MAX_RST;
        cfg_reg[ppmfd_pkg::REG_CLAMP_MIN] = ppmfd_pkg::CLAMP_MIN_RST;
        cfg_reg[ppmfd_pkg::REG_CLAMP_MAX] = ppmfd_pkg::CLAMP_MAX_RST;
        last_edge = '0;
        synced    = 1'b0;
        slots     = 0;
        frame_queue.delete();
    endfunction

    // indexes past the last register are ignored
    function void write_register(logic [2:0] addr, logic [15:0] data);
        if (addr <= ppmfd_pkg::REG_CLAMP_MAX) begin
            cfg_reg[addr] = data;
        end
    endfunction

    function int unsigned pending();
        return frame_queue.size();
    endfunction

    // classify the interval to the previous edge and queue any frame it closes
    function void note_edge(logic [31:0] stamp);
        logic [31:0]  gap;
        logic [15:0]  v;
        chan_result_t r;
        int unsigned  i;
        gap = stamp - last_edge;
        last_edge = stamp;
        if (gap >= cfg_reg[ppmfd_pkg::REG_SYNC_MIN]
            && gap <= cfg_reg[ppmfd_pkg::REG_SYNC_MAX]) begin
            if (synced && slots >= ppmfd_pkg::MIN_FRAME_CHANNELS) begin
                for (i = 0; i < slots; i++) begin
                    r.chan_number    = i[3:0];
                    r.chan_value_us  = chan_store[i];
                    r.frame_channels = slots[4:0];
                    r.frame_last     = (i + 1 == slots);
                    frame_queue.push_back(r);
                end
            end
            slots  = 0;
            synced = 1'b1;
        end else if (gap > cfg_reg[ppmfd_pkg::REG_SYNC_MAX]) begin
            synced = 1'b0;
            slots  = 0;
        end else if (synced && gap >= cfg_reg[ppmfd_pkg::REG_CHAN_MIN]
                     && gap <= cfg_reg[ppmfd_pkg::REG_CHAN_MAX]) begin
            // lower clamp first, upper clamp wins when they cross
            if (slots < ppmfd_pkg::MAX_CHANNELS_DEF) begin
                v = gap[15:0];
                if (v < cfg_reg[ppmfd_pkg::REG_CLAMP_MIN]) v = cfg_reg[ppmfd_pkg::REG_CLAMP_MIN];
                if (v > cfg_reg[ppmfd_pkg::REG_CLAMP_MAX]) v = cfg_reg[ppmfd_pkg::REG_CLAMP_MAX];
                chan_store[slots] = v;
                slots++;
            end
        end else begin
            synced = 1'b0;
            slots  = 0;
        end
    endfunction

    // compare one output item with the oldest owed channel
    function void check_result(logic [31:0] tdata, logic tlast);
        chan_result_t want;
        if (frame_queue.size() == 0) begin
            $error("unexpected item: tdata %h tlast %b", tdata, tlast);
            errors++;
            return;
        end
        want = frame_queue.pop_front();
        if (tdata[3:0] !== want.chan_number) begin
            $error("chan_number: expected %0d, got %0d", want.chan_number, tdata[3:0]);
            errors++;
        end
        if (tdata[19:4] !== want.chan_value_us) begin
            $error("chan_value_us: expected %0d, got %0d", want.chan_value_us, tdata[19:4]);
            errors++;
        end
        if (tdata[24:20] !== want.frame_channels) begin
            $error("frame_channels: expected %0d, got %0d", want.frame_channels, tdata[24:20]);
            errors++;
        end
        if (tlast !== want.frame_last) begin
            $error("frame_last: expected %0d, got %0d", want.frame_last, tlast);
            errors++;
        end
        if (tdata[31:25] !== 7'd0) begin
            $error("zero pad: expected 0, got %0h", tdata[31:25]);
            errors++;
        end
    endfunction
endclass

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned QUIET_LIMIT = 3000;
    localparam int unsigned LONG_HOLD   = 400;
    // indexes with no register behind them
    localparam logic [ppmfd_pkg::CFG_ADDR_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [ppmfd_pkg::CFG_ADDR_W-1:0] REG_SPARE_B = 3'd7;

    logic                             aclk;
    logic                             aresetn;
    logic [ppmfd_pkg::S_TDATA_W-1:0]  s_tdata;
    logic                             s_tvalid;
    logic                             s_tready;
    logic [ppmfd_pkg::M_TDATA_W-1:0]  m_tdata;
    logic                             m_tvalid;
    logic                             m_tready;
    logic                             m_tlast;
    logic                             cfg_wr_en;
    logic [ppmfd_pkg::CFG_ADDR_W-1:0] cfg_addr;
    logic [ppmfd_pkg::CFG_DATA_W-1:0] cfg_wr_data;

    ppm_frame_scoreboard board = new();

    logic [31:0] edge_clock;
    int unsigned edges_sent;
    int unsigned quiet_cycles;
    bit          calm;
    bit          hold_off_req;

    ppm_frame_decoder_core uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tdata     (s_tdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .m_tdata     (m_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tlast     (m_tlast),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // mostly short gaps, now and then a long one
    function automatic int unsigned idle_len();
        int unsigned r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    function automatic int unsigned pick_sync_gap();
        int unsigned lo, hi;
        lo = board.cfg_reg[ppmfd_pkg::REG_SYNC_MIN];
        hi = board.cfg_reg[ppmfd_pkg::REG_SYNC_MAX];
        if (lo > hi) return $urandom_range(0, 65535);
        return $urandom_range(hi, lo);
    endfunction

    // channel pulse, kept below the sync window where the two overlap
    function automatic int unsigned pick_pulse();
        int unsigned lo, hi, smin, smax;
        lo   = board.cfg_reg[ppmfd_pkg::REG_CHAN_MIN];
        hi   = board.cfg_reg[ppmfd_pkg::REG_CHAN_MAX];
        smin = board.cfg_reg[ppmfd_pkg::REG_SYNC_MIN];
        smax = board.cfg_reg[ppmfd_pkg::REG_SYNC_MAX];
        if (lo > hi) return $urandom_range(0, 65535);
        if (smin <= smax && smin > lo && smin <= hi) hi = smin - 1;
        return $urandom_range(hi, lo);
    endfunction

    function automatic int unsigned pick_frame_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 8) return $urandom_range(0, 1);
        if (r < 78) return $urandom_range(2, 6);
        if (r < 94) return $urandom_range(7, 15);
        return $urandom_range(16, 18);
    endfunction

    // offer one edge timestamp and hold it until taken
    task automatic send_at(input logic [31:0] stamp);
        int unsigned g;
        g = idle_len();
        edge_clock = stamp;
        @(negedge aclk);
        if (g > 0) begin
            s_tvalid = 1'b0;
            repeat (g) @(negedge aclk);
        end
        s_tdata  = stamp;
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        board.note_edge(stamp);
        edges_sent++;
    endtask

    task automatic send_gap(input logic [31:0] gap);
        send_at(edge_clock + gap);
    endtask

    // stop offering and let every owed channel out before touching registers
    task automatic drain();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (board.pending() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [ppmfd_pkg::CFG_ADDR_W-1:0] addr,
                             input logic [ppmfd_pkg::CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_wr_en   = 1'b1;
        cfg_addr    = addr;
        cfg_wr_data = data;
        @(posedge aclk);
        board.write_register(addr, data);
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    task automatic set_windows(input logic [15:0] smin, input logic [15:0] smax,
                               input logic [15:0] cmin, input logic [15:0] cmax,
                               input logic [15:0] clmin, input logic [15:0] clmax);
        write_reg(ppmfd_pkg::REG_SYNC_MIN, smin);
        write_reg(ppmfd_pkg::REG_SYNC_MAX, smax);
        write_reg(ppmfd_pkg::REG_CHAN_MIN, cmin);
        write_reg(ppmfd_pkg::REG_CHAN_MAX, cmax);
        write_reg(ppmfd_pkg::REG_CLAMP_MIN, clmin);
        write_reg(ppmfd_pkg::REG_CLAMP_MAX, clmax);
    endtask

    // mostly well-formed frames with random pulses, the rest noise
    task automatic run_frames(input int unsigned count);
        int unsigned stop_at, n, k;
        stop_at = edges_sent + count;
        send_gap(pick_sync_gap());
        while (edges_sent < stop_at) begin
            if ($urandom_range(0, 99) < 75) begin
                n = pick_frame_len();
                for (k = 0; k < n; k++) send_gap(pick_pulse());
                send_gap(pick_sync_gap());
            end else begin
                case ($urandom_range(0, 5))
                    0: send_at($urandom);
                    1: send_gap(board.cfg_reg[ppmfd_pkg::REG_SYNC_MAX] + 1
                                + $urandom_range(0, 100000));
                    2: send_gap($urandom_range(0, board.cfg_reg[ppmfd_pkg::REG_CHAN_MIN]));
                    3: send_gap($urandom_range(0, 65535));
                    4: send_at($urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0000);
                    default: send_at(32'hFFFF_0000 | $urandom_range(0, 65535));
                endcase
            end
        end
    endtask

    // checker on the output channel
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            board.check_result(m_tdata, m_tlast);
        end
    end

    // watchdog on cycles with no item moving on either side
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles = quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // receiver: random stalls, one long hold-off on request
    initial begin
        int unsigned stall;
        stall    = 0;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                stall = LONG_HOLD;
            end
            if (stall > 0) begin
                m_tready = 1'b0;
                stall--;
            end else begin
                m_tready = 1'b1;
                if ($urandom_range(0, 99) < 30) stall = idle_len();
            end
        end
    end

    initial begin
        aresetn      = 1'b0;
        s_tdata      = '0;
        s_tvalid     = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_addr     = '0;
        cfg_wr_data  = '0;
        edge_clock   = '0;
        edges_sent   = 0;
        quiet_cycles = 0;
        calm         = 1'b0;
        hold_off_req = 1'b0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed, default windows: first edge measured from zero
        send_at(32'h0000_0000);
        // sync at the window floor, pulses at both channel limits, frame at sync ceiling
        send_gap(3000);
        send_gap(800);
        send_gap(2200);
        send_gap(1500);
        send_gap(20000);
        // gap just above sync ceiling drops the frame
        send_gap(1000);
        send_gap(1234);
        send_gap(20001);
        // single channel is too short for a frame
        send_gap(3000);
        send_gap(1100);
        send_gap(3000);
        // pulse below the channel floor loses sync
        send_gap(1000);
        send_gap(2000);
        send_gap(799);
        send_gap(3000);
        // frame across the timestamp wrap
        send_at(32'hFFFF_E000);
        send_gap(3000);
        send_gap(1500);
        send_gap(1500);
        send_gap(4000);
        send_at(32'hFFFF_FFFF);
        drain();

        // default windows, with a long receiver hold-off midway
        run_frames(12);
        hold_off_req = 1'b1;
        run_frames(18);
        drain();

        // widest windows, clamps at their extremes
        set_windows(16'd4000, 16'd65535, 16'd0, 16'd3999, 16'd0, 16'd65535);
        run_frames(22);
        drain();

        // crossed clamps: every stored value ends at the upper clamp
        set_windows(16'd2500, 16'd30000, 16'd100, 16'd2400, 16'd65535, 16'd1200);
        run_frames(20);
        drain();

        // overlapping windows: sync wins
        set_windows(16'd1500, 16'd5000, 16'd1000, 16'd3000, 16'd1200, 16'd1400);
        run_frames(20);
        drain();

        // sync only at the top value, channel window over everything, no idling
        calm = 1'b1;
        set_windows(16'd65535, 16'd65535, 16'd0, 16'd65535, 16'd300, 16'd700);
        run_frames(20);
        drain();
        calm = 1'b0;

        // empty windows, and writes to indexes with no register
        set_windows(16'd20000, 16'd10000, 16'd3000, 16'd2000, 16'd1000, 16'd2000);
        write_reg(REG_SPARE_A, 16'hFFFF);
        write_reg(REG_SPARE_B, 16'h5A5A);
        run_frames(10);
        drain();

        // back to the reset windows
        set_windows(ppmfd_pkg::SYNC_MIN_RST, ppmfd_pkg::SYNC_MAX_RST,
                    ppmfd_pkg::CHAN_MIN_RST, ppmfd_pkg::CHAN_MAX_RST,
                    ppmfd_pkg::CLAMP_MIN_RST, ppmfd_pkg::CLAMP_MAX_RST);
        run_frames(15);
        drain();
        repeat (20) @(posedge aclk);

        if (board.errors == 0 && board.pending() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
rtl/core/ppmfd_pkg.sv
rtl/core/ppmfd_ram.sv
rtl/core/ppmfd_ctrl.sv
rtl/core/ppmfd_dp.sv
rtl/core/ppm_frame_decoder_core.sv
test/testbench.sv
